// ===== sv/qs_pkg.sv =====
// ----------------------------------------------------------------------------
// qs_pkg
// shared types for the quicksort engine: sequencer states and the control
// word of the shared compare unit
// ----------------------------------------------------------------------------
package qs_pkg;

   // operand order at the compare unit
   typedef enum logic [0:0] {
      CMP_ITEM_FIRST  = 1'b0,   // stored word goes before the pivot
      CMP_PIVOT_FIRST = 1'b1    // pivot goes before the stored word
   } cmp_order_type;

   typedef struct packed {
      logic          ascending;
      cmp_order_type order;
   } cmp_ctrl_type;

   typedef enum logic [13:0] {
      ST_IDLE      = 14'h0001,
      ST_INIT      = 14'h0002,
      ST_POP       = 14'h0004,
      ST_POP_WAIT  = 14'h0008,
      ST_PIVOT     = 14'h0010,
      ST_SCAN_I    = 14'h0020,
      ST_SCAN_J    = 14'h0040,
      ST_SWAP1     = 14'h0080,
      ST_SWAP2     = 14'h0100,
      ST_PUSH_R    = 14'h0200,
      ST_PUSH_L    = 14'h0400,
      ST_EMIT_RD   = 14'h0800,
      ST_EMIT_LOAD = 14'h1000,
      ST_EMIT_WAIT = 14'h2000
   } state_type;

endpackage

// ===== sv/qs_cmp.sv =====
// ----------------------------------------------------------------------------
// qs_cmp
// shared compare unit: tells whether one word goes strictly before another
// in the selected sort direction
// ----------------------------------------------------------------------------
module qs_cmp #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic signed [VALUE_WIDTH-1:0] item,
   input  logic signed [VALUE_WIDTH-1:0] pivot,
   input  qs_pkg::cmp_ctrl_type          ctrl,
   output logic                          precedes
);
   import qs_pkg::*;

   logic signed [VALUE_WIDTH-1:0] lhs;
   logic signed [VALUE_WIDTH-1:0] rhs;

   always_comb begin
      if (ctrl.order == CMP_PIVOT_FIRST) begin
         lhs = pivot;
         rhs = item;
      end else begin
         lhs = item;
         rhs = pivot;
      end
      // signed two's complement order, flipped for descending
      precedes = ctrl.ascending ? (lhs < rhs) : (lhs > rhs);
   end

endmodule

// ===== sv/quicksort_engine.sv =====
// ----------------------------------------------------------------------------
// quicksort_engine
// collects a set of signed words, sorts it in place with hoare-partition
// quicksort over an explicit range stack, then streams the sorted set out
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_item_value, req_item_last
//   rsp_      out         rsp_valid/rsp_ready    rsp_sorted_value, rsp_sorted_last,
//                                                rsp_items_dropped
//   csr_      in          csr_wr_en              csr_wr_data (sort_ascending)
//
// load takes one cycle per word; a word beyond MAX_ITEMS is dropped and flagged
// the sort is paced by the single read port of the element store through its scan steps,
// swaps and partitioned ranges
// output steps through ST_EMIT_RD, ST_EMIT_LOAD and ST_EMIT_WAIT for each word, plus any rsp_ready stall
// req_ready is low from the last word of a set until its last word is taken
// reset clears the control state; store and stack need no clearing
// ----------------------------------------------------------------------------
module quicksort_engine #(
   parameter int MAX_ITEMS   = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_item_value,
   input  logic                          req_item_last,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_sorted_value,
   output logic                          rsp_sorted_last,
   output logic                          rsp_items_dropped,
   // configuration
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);
   import qs_pkg::*;

   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int SK_W  = 2 * IDX_W;

   // control state
   state_type        state_ff,  state_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             ovf_ff,    ovf_in;
   logic             asc_ff,    asc_in;
   logic [CNT_W-1:0] depth_ff,  depth_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [CNT_W-1:0]              n_ff,     n_in;
   logic [IDX_W-1:0]              lo_ff,    lo_in;
   logic [IDX_W-1:0]              hi_ff,    hi_in;
   logic [IDX_W-1:0]              i_ff,     i_in;
   logic [IDX_W-1:0]              j_ff,     j_in;
   logic [IDX_W-1:0]              k_ff,     k_in;
   logic signed [VALUE_WIDTH-1:0] pivot_ff, pivot_in;
   logic signed [VALUE_WIDTH-1:0] vi_ff,    vi_in;
   logic signed [VALUE_WIDTH-1:0] vj_ff,    vj_in;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff,  rsp_last_in;
   logic                          rsp_drop_ff,  rsp_drop_in;

   // element store, one write and one registered read port
   logic signed [VALUE_WIDTH-1:0] store_mem [MAX_ITEMS];
   logic signed [VALUE_WIDTH-1:0] st_rd_data_ff;
   logic [IDX_W-1:0]              st_rd_addr;
   logic                          st_we;
   logic [IDX_W-1:0]              st_wr_addr;
   logic signed [VALUE_WIDTH-1:0] st_wr_data;

   // range stack, {hi, lo} per entry
   logic [SK_W-1:0]  stack_mem [MAX_ITEMS];
   logic [SK_W-1:0]  sk_rd_data_ff;
   logic [IDX_W-1:0] sk_rd_addr;
   logic             sk_we;
   logic [IDX_W-1:0] sk_wr_addr;
   logic [SK_W-1:0]  sk_wr_data;
   logic [IDX_W-1:0] sk_lo;
   logic [IDX_W-1:0] sk_hi;

   // shared compare unit
   cmp_ctrl_type cmp_ctrl;
   logic         cmp_before;

   assign sk_lo = sk_rd_data_ff[IDX_W-1:0];
   assign sk_hi = sk_rd_data_ff[SK_W-1:IDX_W];

   assign cmp_ctrl.ascending = asc_ff;
   assign cmp_ctrl.order     = (state_ff == ST_SCAN_J) ? CMP_PIVOT_FIRST : CMP_ITEM_FIRST;

   qs_cmp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cmp (
      .item     (st_rd_data_ff),
      .pivot    (pivot_ff),
      .ctrl     (cmp_ctrl),
      .precedes (cmp_before)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sorted_value  = rsp_value_ff;
   assign rsp_sorted_last   = rsp_last_ff;
   assign rsp_items_dropped = rsp_drop_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      asc_in       = asc_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      vi_in        = vi_ff;
      vj_in        = vj_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      st_rd_addr   = '0;
      st_we        = 1'b0;
      st_wr_addr   = '0;
      st_wr_data   = req_item_value;
      sk_rd_addr   = '0;
      sk_we        = 1'b0;
      sk_wr_addr   = depth_ff[IDX_W-1:0];
      sk_wr_data   = '0;

      if (csr_wr_en) begin
         asc_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // store the word while there is room, else just flag it
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  st_we      = 1'b1;
                  st_wr_addr = count_ff[IDX_W-1:0];
                  count_in   = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_item_last) begin
                  n_in     = count_in;
                  k_in     = '0;
                  state_in = (count_in >= CNT_W'(2)) ? ST_INIT : ST_EMIT_RD;
               end
            end
         end
         ST_INIT: begin
            // whole set is the first range
            sk_we      = 1'b1;
            sk_wr_addr = '0;
            sk_wr_data = {IDX_W'(n_ff - CNT_W'(1)), IDX_W'(0)};
            depth_in   = CNT_W'(1);
            state_in   = ST_POP;
         end
         ST_POP: begin
            if (depth_ff == '0) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               sk_rd_addr = IDX_W'(depth_ff - CNT_W'(1));
               depth_in   = depth_ff - CNT_W'(1);
               state_in   = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            lo_in = sk_lo;
            hi_in = sk_hi;
            if (sk_lo >= sk_hi) begin
               state_in = ST_POP;
            end else begin
               st_rd_addr = sk_lo;
               state_in   = ST_PIVOT;
            end
         end
         ST_PIVOT: begin
            // first element is the pivot; the left scan would stop on it, so the right scan starts
            pivot_in   = st_rd_data_ff;
            vi_in      = st_rd_data_ff;
            i_in       = lo_ff;
            j_in       = hi_ff;
            st_rd_addr = hi_ff;
            state_in   = ST_SCAN_J;
         end
         ST_SCAN_I: begin
            if ((i_ff < hi_ff) && cmp_before) begin
               i_in       = i_ff + IDX_W'(1);
               st_rd_addr = i_ff + IDX_W'(1);
            end else begin
               vi_in      = st_rd_data_ff;
               st_rd_addr = j_ff;
               state_in   = ST_SCAN_J;
            end
         end
         ST_SCAN_J: begin
            if ((j_ff > lo_ff) && cmp_before) begin
               j_in       = j_ff - IDX_W'(1);
               st_rd_addr = j_ff - IDX_W'(1);
            end else begin
               vj_in    = st_rd_data_ff;
               state_in = (i_ff >= j_ff) ? ST_PUSH_R : ST_SWAP1;
            end
         end
         ST_SWAP1: begin
            st_we      = 1'b1;
            st_wr_addr = j_ff;
            st_wr_data = vi_ff;
            state_in   = ST_SWAP2;
         end
         ST_SWAP2: begin
            st_we      = 1'b1;
            st_wr_addr = i_ff;
            st_wr_data = vj_ff;
            i_in       = i_ff + IDX_W'(1);
            j_in       = j_ff - IDX_W'(1);
            st_rd_addr = i_ff + IDX_W'(1);
            state_in   = ST_SCAN_I;
         end
         ST_PUSH_R: begin
            // right part j+1..hi, pushed first so the left part pops first
            if (({1'b0, j_ff} + (IDX_W+1)'(1) < {1'b0, hi_ff}) &&
                (depth_ff < CNT_W'(MAX_ITEMS))) begin
               sk_we      = 1'b1;
               sk_wr_data = {hi_ff, j_ff + IDX_W'(1)};
               depth_in   = depth_ff + CNT_W'(1);
            end
            state_in = ST_PUSH_L;
         end
         ST_PUSH_L: begin
            if ((lo_ff < j_ff) && (depth_ff < CNT_W'(MAX_ITEMS))) begin
               sk_we      = 1'b1;
               sk_wr_data = {j_ff, lo_ff};
               depth_in   = depth_ff + CNT_W'(1);
            end
            state_in = ST_POP;
         end
         ST_EMIT_RD: begin
            st_rd_addr = k_ff;
            state_in   = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = st_rd_data_ff;
            rsp_last_in  = ((CNT_W'(k_ff) + CNT_W'(1)) == n_ff);
            rsp_drop_in  = ovf_ff;
            state_in     = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         asc_ff       <= 1'b1;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         asc_ff       <= asc_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      pivot_ff     <= pivot_in;
      vi_ff        <= vi_in;
      vj_ff        <= vj_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   // element store
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_wr_addr] <= st_wr_data;
      end
      st_rd_data_ff <= store_mem[st_rd_addr];
   end

   // range stack
   always_ff @(posedge clock) begin
      if (sk_we) begin
         stack_mem[sk_wr_addr] <= sk_wr_data;
      end
      sk_rd_data_ff <= stack_mem[sk_rd_addr];
   end

   // the two channels are never open at once
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response open together");

   // fill count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("fill count beyond store size");

   // right scan never leaves its range
   a_scan_j_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_J) |-> (j_ff >= lo_ff) && (j_ff <= hi_ff))
      else $error("right scan index out of range");

   // a last word closes the input until the set is out
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_item_last) |=> !req_ready)
      else $error("input still open after last word");

   // taking the last sorted word reopens the input
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_sorted_last) |=> req_ready)
      else $error("input not reopened after set");

endmodule

// ===== tb/sv/quicksort_engine_tb.sv =====
// ----------------------------------------------------------------------------
// quicksort_engine_tb
// self-checking bench for the quicksort engine: streams sets of signed words
// in bursts, predicts each sorted set in a small scoreboard and checks every
// word that comes back, under both sort orders and with store overflow
// ----------------------------------------------------------------------------
module quicksort_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH   = 64;
   localparam int WORD_BITS     = 32;
   localparam int TARGET_WORDS  = 350;
   localparam int SETTLE_CYCLES = 16;       // engine drops back to idle after the last word
   localparam int LIMIT_CYCLES  = 600000;
   localparam int MAX_PRINTS    = 40;

   localparam logic signed [WORD_BITS-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_BITS-1:0] VAL_MAX = 32'sh7fff_ffff;

   // shape of the values in one set
   typedef enum int {
      SET_SPREAD,    // full 32-bit range with the odd extreme
      SET_NARROW,    // a handful of values, lots of duplicates
      SET_RISING,    // already in ascending order
      SET_FALLING    // already in descending order
   } set_shape_type;

   // how the result side throttles rsp_ready
   typedef enum int {
      RX_ALWAYS,     // never stalls
      RX_COIN,       // ready on a coin toss
      RX_PERIODIC,   // periodic stalls keyed to the cycle counter
      RX_LONG        // occasional long stalls
   } rx_mode_type;

   typedef struct {
      logic signed [WORD_BITS-1:0] value;
      logic                        last;
      logic                        dropped;
   } sorted_word_type;

   // -------------------------------------------------------------------------
   // scoreboard: mirrors the element store and turns each finished set into
   // the sequence of sorted words the engine must produce
   // -------------------------------------------------------------------------
   class sort_scoreboard;
      logic signed [WORD_BITS-1:0] loaded[$];
      sorted_word_type             sorted_words[$];
      bit                          overflow;
      bit                          ascending = 1'b1;
      int                          errors;

      function void set_order(bit asc);
         ascending = asc;
      endfunction

      function int pending();
         return sorted_words.size();
      endfunction

      task report_mismatch(string msg);
         if (errors < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      // insertion sort in the order latched at the last word of the set
      function void sort_loaded();
         logic signed [WORD_BITS-1:0] key;
         int                          b;
         for (int a = 1; a < loaded.size(); a++) begin
            key = loaded[a];
            b   = a - 1;
            while (b >= 0 && (ascending ? (loaded[b] > key) : (loaded[b] < key))) begin
               loaded[b+1] = loaded[b];
               b--;
            end
            loaded[b+1] = key;
         end
      endfunction

      // accepted input word
      task note_word(logic signed [WORD_BITS-1:0] value, logic last);
         sorted_word_type w;
         if (loaded.size() < STORE_DEPTH)
            loaded.push_back(value);
         else
            overflow = 1'b1;         // store full, word is dropped
         if (!last)
            return;
         sort_loaded();
         foreach (loaded[k]) begin
            w.value   = loaded[k];
            w.last    = (k == loaded.size() - 1);
            w.dropped = overflow;
            sorted_words.push_back(w);
         end
         loaded.delete();
         overflow = 1'b0;
      endtask

      // accepted result word
      task check_word(logic signed [WORD_BITS-1:0] value, logic last, logic dropped);
         sorted_word_type w;
         if (sorted_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word value %0d", value));
            return;
         end
         w = sorted_words.pop_front();
         if (value !== w.value)
            report_mismatch($sformatf("value %0d, wanted %0d", value, w.value));
         if (last !== w.last)
            report_mismatch($sformatf("last flag %b, wanted %b (value %0d)",
                                      last, w.last, w.value));
         if (dropped !== w.dropped)
            report_mismatch($sformatf("dropped flag %b, wanted %b (value %0d)",
                                      dropped, w.dropped, w.value));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block ports
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic signed [WORD_BITS-1:0] req_item_value = '0;
   logic                        req_item_last  = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b0;
   logic signed [WORD_BITS-1:0] rsp_sorted_value;
   logic                        rsp_sorted_last;
   logic                        rsp_items_dropped;
   logic                        csr_wr_en      = 1'b0;
   logic                        csr_wr_data    = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   quicksort_engine #(
      .MAX_ITEMS   (STORE_DEPTH),
      .VALUE_WIDTH (WORD_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_item_value    (req_item_value),
      .req_item_last     (req_item_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sorted_value  (rsp_sorted_value),
      .rsp_sorted_last   (rsp_sorted_last),
      .rsp_items_dropped (rsp_items_dropped),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   sort_scoreboard sb = new();

   int cycles;
   int words_sent;
   int burst_left;
   logic signed [WORD_BITS-1:0] set_buf[$];

   // -------------------------------------------------------------------------
   // run limit: anything still going at this point has hung
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // result side: check each accepted word, then pick the next rsp_ready
   // values read here are the ones that stood at the edge
   // -------------------------------------------------------------------------
   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_mode_left;
   int          rx_stall_left;

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_word(rsp_sorted_value, rsp_sorted_last, rsp_items_dropped);

      // switch throttling style when rx_mode_left runs out
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(20, 120);
      end else begin
         rx_mode_left--;
      end

      case (rx_mode)
         RX_ALWAYS:   rsp_ready <= 1'b1;
         RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         RX_PERIODIC: rsp_ready <= (cycles % 3 != 0);
         default: begin
            if (rx_stall_left > 0) begin
               rx_stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
               rx_stall_left = $urandom_range(1, 8);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // input side
   // -------------------------------------------------------------------------

   // one input word; bursts of random length with random gaps in between
   task automatic send_word(input logic signed [WORD_BITS-1:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_item_value <= value;
      req_item_last  <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_word(value, last);
      burst_left--;
      words_sent++;
   endtask

   // whole set from set_buf, last flag on the final word
   task automatic send_buffer();
      foreach (set_buf[k])
         send_word(set_buf[k], k == set_buf.size() - 1);
   endtask

   // sort order only changes once the engine has emptied out
   task automatic write_order(input bit asc);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= asc;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_order(asc);
   endtask

   // random set contents in one of the shapes above
   task automatic build_set(input int size, input set_shape_type shape);
      logic signed [WORD_BITS-1:0] base;
      logic signed [WORD_BITS-1:0] v;
      set_buf.delete();
      base = $signed(WORD_BITS'($urandom_range(0, 2000))) - 1000;
      for (int k = 0; k < size; k++) begin
         case (shape)
            SET_NARROW:  v = $signed(WORD_BITS'($urandom_range(0, 7))) - 4;
            SET_RISING:  v = base + k * 3;
            SET_FALLING: v = base - k * 3;
            default: begin
               case ($urandom_range(0, 11))
                  0:       v = VAL_MIN;
                  1:       v = VAL_MAX;
                  2:       v = '0;
                  3:       v = -1;
                  default: v = $urandom;
               endcase
            end
         endcase
         set_buf.push_back(v);
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      int            set_idx;
      int            size;
      set_shape_type shape;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed sets, first ascending then descending
      for (int pass = 0; pass < 2; pass++) begin
         write_order(pass == 0);
         set_buf = '{VAL_MAX};                        // single word set
         send_buffer();
         set_buf = '{0, -1, 1, VAL_MIN, VAL_MAX, VAL_MIN + 1, VAL_MAX - 1};
         send_buffer();
         set_buf = '{7, 7, -7, 7};                    // repeated values
         send_buffer();
      end

      // random sets; a full store, a drop of the last word and a longer
      // overflow are forced at fixed points
      set_idx = 0;
      while (words_sent < TARGET_WORDS) begin
         shape = set_shape_type'($urandom_range(0, 3));
         case (set_idx)
            1:       size = STORE_DEPTH;
            4:       size = STORE_DEPTH + 1;
            8:       size = $urandom_range(STORE_DEPTH + 2, STORE_DEPTH + 8);
            default: size = ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(1, 12);
         endcase
         build_set(size, shape);
         send_buffer();
         if ($urandom_range(0, 2) == 0)
            write_order(1'($urandom_range(0, 1)));
         set_idx++;
      end

      // drain
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/qs_pkg.sv
sv/qs_cmp.sv
sv/quicksort_engine.sv
tb/sv/quicksort_engine_tb.sv
